/* hdl/nbt_pkg.sv */
`default_nettype none
package nbt_pkg;

	localparam int NUM_ENTRIES_DEF = 16;
	localparam int MAX_ITEMS = 16;

	localparam logic [4:0] STAB_MAX = 5'd25;
	localparam logic [5:0] AGE_MAX = 6'd63;

	localparam logic [7:0] MIN_HELLO_RST = 8'd5;
	localparam logic [7:0] MAX_HELLO_RST = 8'd30;
	localparam logic [4:0] STAB_THR_RST = 5'd10;
	localparam logic [5:0] TIMEOUT_RST = 6'd45;

	// Stability tiers and the fixed intervals between them.
	localparam logic [4:0] TIER_TOP = 5'd20;
	localparam logic [4:0] TIER_HIGH = 5'd15;
	localparam logic [4:0] TIER_MID = 5'd10;
	localparam logic [4:0] TIER_LOW = 5'd5;
	localparam logic [7:0] IVL_HIGH = 8'd20;
	localparam logic [7:0] IVL_MID = 8'd15;
	localparam logic [7:0] IVL_LOW = 8'd10;

	localparam logic [2:0] CMD_HELLO = 3'd0;
	localparam logic [2:0] CMD_TICK = 3'd1;
	localparam logic [2:0] CMD_PURGE = 3'd2;
	localparam logic [2:0] CMD_QUERY = 3'd3;
	localparam logic [2:0] CMD_LIST = 3'd4;
	localparam logic [2:0] CMD_LIST_NAMED = 3'd5;

	localparam logic [1:0] REG_MIN_HELLO = 2'd0;
	localparam logic [1:0] REG_MAX_HELLO = 2'd1;
	localparam logic [1:0] REG_STAB_THR = 2'd2;
	localparam logic [1:0] REG_TIMEOUT = 2'd3;

	typedef struct packed {
		logic [2:0] command;
		logic [31:0] neighbor_addr;
		logic has_name;
	} req_t;

	typedef struct packed {
		logic [31:0] out_addr;
		logic found;
		logic is_new;
		logic table_full;
		logic [4:0] stability;
		logic [7:0] hello_interval;
		logic is_stable;
		logic last;
	} rsp_t;

	typedef struct packed {
		logic [2:0] op;
		logic [31:0] addr;
		logic named;
	} cmd_t;

	typedef struct packed {
		logic [31:0] addr;
		logic named;
		logic [5:0] age;
		logic [4:0] stab;
	} entry_t;

	typedef struct packed {
		logic [7:0] min_hello;
		logic [7:0] max_hello;
		logic [4:0] stab_thr;
		logic [5:0] timeout;
	} cfg_t;

	function automatic logic [7:0] tier_interval(input logic [4:0] s, input cfg_t cfg);
		logic [7:0] r;
		if (s > TIER_TOP) r = cfg.max_hello;
		else if (s > TIER_HIGH) r = IVL_HIGH;
		else if (s > TIER_MID) r = IVL_MID;
		else if (s > TIER_LOW) r = IVL_LOW;
		else r = cfg.min_hello;
		return r;
	endfunction

	function automatic rsp_t make_item(input logic [31:0] addr, input logic found,
			input logic is_new, input logic full, input logic [4:0] stab,
			input logic known, input logic last, input cfg_t cfg);
		rsp_t r;
		r.out_addr = addr;
		r.found = found;
		r.is_new = is_new;
		r.table_full = full;
		r.stability = stab;
		r.hello_interval = known ? tier_interval(stab, cfg) : cfg.min_hello;
		r.is_stable = known && (stab >= cfg.stab_thr);
		r.last = last;
		return r;
	endfunction

endpackage
`default_nettype wire

/* hdl/nbt_front.sv */
`default_nettype none
module nbt_front import nbt_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_stall,
	input wire req_t req,
	output logic q_valid,
	output cmd_t q_item,
	input wire logic q_pop
);

	cmd_t slot_q [2];
	logic wp_q;
	logic rp_q;
	logic [1:0] cnt_q;
	logic known_cmd;
	logic push;

	// Unused command codes are accepted and dropped here.
	assign known_cmd = req.command <= CMD_LIST_NAMED;
	assign req_stall = cnt_q[1];
	assign push = req_valid && !req_stall && known_cmd;
	assign q_valid = cnt_q != 2'd0;
	assign q_item = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= '{op: req.command, addr: req.neighbor_addr, named: req.has_name};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (q_pop) rp_q <= !rp_q;
			if (push && !q_pop) cnt_q <= cnt_q + 2'd1;
			else if (!push && q_pop) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule
`default_nettype wire

/* hdl/nbt_back.sv */
`default_nettype none
module nbt_back import nbt_pkg::*; #(
	parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [7:0] cfg_data,
	input wire logic q_valid,
	input wire cmd_t q_item,
	output logic q_pop,
	output logic rsp_valid,
	input wire logic rsp_stall,
	output rsp_t rsp
);

	localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_ENTRIES - 1);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam logic [CW-1:0] ITEM_CAP = CW'(MAX_ITEMS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD = 2'd1;
	localparam logic [1:0] ST_EV = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	entry_t mem [NUM_ENTRIES];
	entry_t rd_q;
	logic [NUM_ENTRIES-1:0] valid_q;
	cfg_t cfg_q;
	logic [1:0] state_q;
	cmd_t cur_q;
	logic [IW-1:0] idx_q;
	logic hit_q;
	logic [IW-1:0] hit_idx_q;
	entry_t hit_rec_q;
	logic free_q;
	logic [IW-1:0] free_idx_q;
	logic pend_q;
	rsp_t pend_item_q;
	logic [CW-1:0] cnt_q;
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic out_free;
	logic cur_valid;
	logic lmatch;
	logic mem_we;
	logic [IW-1:0] mem_wa;
	entry_t mem_wd;
	logic val_set;
	logic val_clr;
	logic emit;
	rsp_t emit_item;
	logic step;
	logic pend_load;
	logic done_ok;
	logic [4:0] hit_stab_nx;
	rsp_t last_item;

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign cur_valid = valid_q[idx_q];
	assign lmatch = cur_valid && (rd_q.age < cfg_q.timeout)
		&& ((cur_q.op != CMD_LIST_NAMED) || rd_q.named);
	assign hit_stab_nx = (hit_rec_q.stab == STAB_MAX) ? STAB_MAX : hit_rec_q.stab + 5'd1;
	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_comb begin
		last_item = pend_item_q;
		last_item.last = 1'b1;
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_q;
		mem_wd = rd_q;
		val_set = 1'b0;
		val_clr = 1'b0;
		emit = 1'b0;
		emit_item = '0;
		step = 1'b0;
		pend_load = 1'b0;
		done_ok = 1'b0;
		case (state_q)
			ST_EV: begin
				case (cur_q.op)
					CMD_TICK: begin
						step = 1'b1;
						if (cur_valid && rd_q.age != AGE_MAX) begin
							mem_we = 1'b1;
							mem_wd.age = rd_q.age + 6'd1;
						end
					end
					CMD_PURGE: begin
						step = 1'b1;
						val_clr = cur_valid && (rd_q.age > cfg_q.timeout);
					end
					CMD_LIST, CMD_LIST_NAMED: begin
						if (lmatch && cnt_q < ITEM_CAP) begin
							// A held item leaves once a later one matches, or as last at done.
							if (pend_q) begin
								if (out_free) begin
									emit = 1'b1;
									emit_item = pend_item_q;
									pend_load = 1'b1;
									step = 1'b1;
								end
							end else begin
								pend_load = 1'b1;
								step = 1'b1;
							end
						end else begin
							step = 1'b1;
						end
					end
					default: step = 1'b1;
				endcase
			end
			ST_DONE: begin
				case (cur_q.op)
					CMD_HELLO: begin
						if (out_free) begin
							emit = 1'b1;
							done_ok = 1'b1;
							if (hit_q) begin
								mem_we = 1'b1;
								mem_wa = hit_idx_q;
								mem_wd = '{addr: hit_rec_q.addr, named: hit_rec_q.named,
									age: 6'd0, stab: hit_stab_nx};
								emit_item = make_item(cur_q.addr, 1'b1, 1'b0, 1'b0,
									hit_stab_nx, 1'b1, 1'b1, cfg_q);
							end else if (free_q) begin
								mem_we = 1'b1;
								mem_wa = free_idx_q;
								mem_wd = '{addr: cur_q.addr, named: cur_q.named,
									age: 6'd0, stab: 5'd0};
								val_set = 1'b1;
								emit_item = make_item(cur_q.addr, 1'b0, 1'b1, 1'b0,
									5'd0, 1'b0, 1'b1, cfg_q);
							end else begin
								emit_item = make_item(cur_q.addr, 1'b0, 1'b0, 1'b1,
									5'd0, 1'b0, 1'b1, cfg_q);
							end
						end
					end
					CMD_QUERY: begin
						if (out_free) begin
							emit = 1'b1;
							done_ok = 1'b1;
							emit_item = make_item(cur_q.addr, hit_q, 1'b0, 1'b0,
								hit_q ? hit_rec_q.stab : 5'd0, hit_q, 1'b1, cfg_q);
						end
					end
					CMD_LIST, CMD_LIST_NAMED: begin
						if (out_free) begin
							emit = 1'b1;
							done_ok = 1'b1;
							if (pend_q) begin
								emit_item = last_item;
							end else begin
								emit_item = '0;
								emit_item.last = 1'b1;
							end
						end
					end
					default: done_ok = 1'b1;
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_q <= mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) cur_q <= q_item;
		if (state_q == ST_EV && (cur_q.op == CMD_HELLO || cur_q.op == CMD_QUERY)) begin
			if (cur_valid && rd_q.addr == cur_q.addr && !hit_q) begin
				hit_idx_q <= idx_q;
				hit_rec_q <= rd_q;
			end
			if (!cur_valid && !free_q) free_idx_q <= idx_q;
		end
		if (pend_load) begin
			pend_item_q <= make_item(rd_q.addr, 1'b1, 1'b0, 1'b0, rd_q.stab, 1'b1,
				1'b0, cfg_q);
		end
		if (emit) rsp_q <= emit_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{min_hello: MIN_HELLO_RST, max_hello: MAX_HELLO_RST,
				stab_thr: STAB_THR_RST, timeout: TIMEOUT_RST};
			valid_q <= '0;
			state_q <= ST_IDLE;
			idx_q <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			pend_q <= 1'b0;
			cnt_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MIN_HELLO: cfg_q.min_hello <= cfg_data;
					REG_MAX_HELLO: cfg_q.max_hello <= cfg_data;
					REG_STAB_THR: cfg_q.stab_thr <= cfg_data[4:0];
					REG_TIMEOUT: cfg_q.timeout <= cfg_data[5:0];
					default: begin
					end
				endcase
			end
			if (val_set) valid_q[free_idx_q] <= 1'b1;
			if (val_clr) valid_q[idx_q] <= 1'b0;
			if (emit) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
			if (pend_load) begin
				pend_q <= 1'b1;
				cnt_q <= cnt_q + CW'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						idx_q <= '0;
						hit_q <= 1'b0;
						free_q <= 1'b0;
						pend_q <= 1'b0;
						cnt_q <= '0;
						state_q <= ST_RD;
					end
				end
				ST_RD: state_q <= ST_EV;
				ST_EV: begin
					if (cur_q.op == CMD_HELLO || cur_q.op == CMD_QUERY) begin
						if (cur_valid && rd_q.addr == cur_q.addr) hit_q <= 1'b1;
						if (!cur_valid) free_q <= 1'b1;
					end
					if (step) begin
						if (idx_q == LAST_IDX) begin
							state_q <= ST_DONE;
						end else begin
							idx_q <= idx_q + IW'(1);
							state_q <= ST_RD;
						end
					end
				end
				ST_DONE: begin
					if (done_ok) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

/* hdl/neighbor_table_aging_stability_unit.sv */
// Channel  Direction  Signals                        Beat taken when
// req      in         req_valid, req_stall, req      req_valid && !req_stall
// rsp      out        rsp_valid, rsp_stall, rsp      rsp_valid && !rsp_stall
// cfg      in         cfg_we, cfg_index, cfg_data    cfg_we
//
// Every command walks the whole table: a read state and an evaluate state for each
// entry through the table memory's registered read port, then a done state.
// A two-deep command queue lets the input keep accepting while the walk runs.
// A list command pauses its walk at a match while the result register is stalled.
// Reset clears the valid marks and restores the default configuration; entry contents need no clearing.
`default_nettype none
module neighbor_table_aging_stability_unit import nbt_pkg::*; #(
	parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_stall,
	input wire req_t req,
	output logic rsp_valid,
	input wire logic rsp_stall,
	output rsp_t rsp,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [7:0] cfg_data
);

	logic q_valid;
	logic q_pop;
	cmd_t q_item;

	nbt_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop)
	);

	nbt_back #(.NUM_ENTRIES(NUM_ENTRIES)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

endmodule
`default_nettype wire

/* hdl/nbt_checker.sv */
`default_nettype none
module nbt_checker import nbt_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire req_t req,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire rsp_t rsp,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [7:0] cfg_data
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result beat changed");

	a_new_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.is_new |-> !rsp.found && !rsp.table_full && rsp.stability == 5'd0)
		else $error("insertion result has inconsistent flags");

	a_full_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.table_full |-> !rsp.found && !rsp.is_stable && rsp.last)
		else $error("table full result has inconsistent flags");

	a_list_mid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |-> rsp.found && !rsp.is_new && !rsp.table_full)
		else $error("non-final beat is not a listed neighbor");

	a_stab_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.stability <= STAB_MAX)
		else $error("stability count out of range");

endmodule

bind neighbor_table_aging_stability_unit nbt_checker u_nbt_checker (.*);
`default_nettype wire
